// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the rising edge, quiet while reset is applied
`define BPA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check sampled on every rising edge, reset included
`define BPA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES_DEF = 4096;

    localparam int WORD_BITS  = 16;
    localparam int WORD_SHIFT = 4;

    localparam int COUNT_W  = 13;
    localparam int START_W  = 12;
    localparam int LIMIT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ZERO    = 2'd2
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    req_load;
        logic    disp_init;
        logic    scan_step;
        logic    hit_take;
        logic    fill_rd;
        logic    fill_wr;
        logic    res_set;
        t_status res_code;
        logic    rsp_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cnt_zero;
        logic op_free;
        logic free_empty;
        logic hit;
        logic nospace;
        logic fill_last;
        logic rsp_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/bpa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [bpa_pkg::COUNT_W-1:0]  run_len;
    logic [bpa_pkg::START_W-1:0]  start_page;

    modport source (output valid, output op, output run_len, output start_page,
                    input ready);
    modport sink   (input valid, input op, input run_len, input start_page,
                    output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STATUS_W-1:0]  status;
    logic [bpa_pkg::PAGE_W-1:0]    alloc_page;

    modport source (output valid, output status, output alloc_page, input ready);
    modport sink   (input valid, input status, input alloc_page, output ready);
endinterface

interface bpa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::LIMIT_W-1:0]  page_limit;

    modport source (output valid, output page_limit, input ready);
    modport sink   (input valid, input page_limit, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = bpa_pkg::WORD_BITS,
    parameter int DEPTH = bpa_pkg::NUM_PAGES_DEF / bpa_pkg::WORD_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    output bpa_pkg::t_cmd      o_cmd,
    input  wire bpa_pkg::t_sts i_sts
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_DISPATCH = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_FILL_RD  = 7'b0010000,
        S_FILL_WR  = 7'b0100000,
        S_RESULT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.disp_init = 1'b1;
                if (i_sts.cnt_zero) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = bpa_pkg::ST_ZERO;
                    n_state        = S_RESULT;
                end else if (!i_sts.op_free) begin
                    n_state = S_SCAN;
                end else if (i_sts.free_empty) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = bpa_pkg::ST_OK;
                    n_state        = S_RESULT;
                end else begin
                    n_state = S_FILL_RD;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_state        = S_FILL_RD;
                end else if (i_sts.nospace) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = bpa_pkg::ST_NOSPACE;
                    n_state        = S_RESULT;
                end
            end
            S_FILL_RD: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = S_FILL_WR;
            end
            S_FILL_WR: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = bpa_pkg::ST_OK;
                    n_state        = S_RESULT;
                end else begin
                    n_state = S_FILL_RD;
                end
            end
            S_RESULT: begin
                if (i_sts.rsp_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `BPA_ASSERT_ALWAYS(a_reset_starts_clear, i_clk, !i_rst_n |=> (r_state == S_CLEAR), "reset did not start the bitmap clear")

endmodule

`default_nettype wire

// ===== rtl/bpa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bpa_dp #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bpa_pkg::t_cmd                  i_cmd,
    output bpa_pkg::t_sts                       o_sts,
    input  wire logic                           i_req_op,
    input  wire logic [bpa_pkg::COUNT_W-1:0]    i_req_run_len,
    input  wire logic [bpa_pkg::START_W-1:0]    i_req_start_page,
    input  wire logic                           i_cfg_valid,
    input  wire logic [bpa_pkg::LIMIT_W-1:0]    i_cfg_page_limit,
    output logic                                o_cfg_ready,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output logic      [bpa_pkg::STATUS_W-1:0]   o_rsp_status,
    output logic      [bpa_pkg::PAGE_W-1:0]     o_rsp_alloc_page
);

    localparam int WB = bpa_pkg::WORD_BITS;
    localparam int WS = bpa_pkg::WORD_SHIFT;
    localparam int NW = (NUM_PAGES + WB - 1) / WB;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW = AW + WS;
    localparam int SW = AW + 1;
    localparam int RW = $clog2(NUM_PAGES + 1);
    localparam int CW = (RW > bpa_pkg::COUNT_W) ? RW : bpa_pkg::COUNT_W;
    localparam int EW = CW + 1;

    logic                          r_op;
    logic [bpa_pkg::COUNT_W-1:0]   r_count;
    logic [bpa_pkg::START_W-1:0]   r_start;
    logic [bpa_pkg::LIMIT_W-1:0]   r_page_limit;
    logic [AW-1:0]                 r_clr_addr;
    logic [SW-1:0]                 r_rd_addr;
    logic [AW-1:0]                 r_ev_idx;
    logic                          r_ev_vld;
    logic [CW-1:0]                 r_carry;
    logic [SW-1:0]                 r_scan_words;
    logic [CW-1:0]                 r_lim;
    logic [XW-1:0]                 r_lo;
    logic [XW-1:0]                 r_hi;
    logic                          r_fill_val;
    logic [AW-1:0]                 r_fw;
    bpa_pkg::t_status              r_res_status;
    logic [bpa_pkg::PAGE_W-1:0]    r_res_page;
    logic                          r_rsp_valid;
    bpa_pkg::t_status              r_rsp_status;
    logic [bpa_pkg::PAGE_W-1:0]    r_rsp_page;

    logic [CW-1:0]         lim_cfg;
    logic [CW-1:0]         lim_cl;
    logic [EW-1:0]         lim_up;
    logic [SW-1:0]         scan_words_n;
    logic                  last_word;
    logic [WB-1:0]         ram_rdata;
    logic [WB-1:0]         used_e;
    logic [WB-1:0][CW-1:0] run_at;
    logic [WB-1:0]         hit_vec;
    logic [WS-1:0]         hk;
    logic                  hit_raw;
    logic                  issue;
    logic [XW-1:0]         end_page;
    logic [EW-1:0]         first_e;
    logic [EW-1:0]         start_e;
    logic [EW-1:0]         fend_e;
    logic [EW-1:0]         np_e;
    logic [EW-1:0]         hi_e;
    logic [AW-1:0]         lo_word;
    logic [AW-1:0]         hi_word;
    logic [WS-1:0]         lo_b;
    logic [WS-1:0]         hi_b;
    logic [WB-1:0]         fill_mask;
    logic [WB-1:0]         fill_data;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WB-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic                  fill_ok;
    logic                  hit_ok;
    logic                  rsp_ok;

    assign lim_cfg      = CW'(r_page_limit);
    assign lim_cl       = (lim_cfg > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : lim_cfg;
    assign lim_up       = EW'(lim_cl) + EW'(WB - 1);
    assign scan_words_n = lim_up[WS +: SW];

    assign last_word = (SW'(r_ev_idx) == (r_scan_words - SW'(1)));

    always_comb begin
        for (int k = 0; k < WB; k++) begin
            used_e[k] = ram_rdata[k]
                        | (last_word && (r_lim[WS-1:0] != '0)
                           && (WS'(k) >= r_lim[WS-1:0]));
        end
    end

    always_comb begin : scan_eval
        logic          uf;
        logic [WS-1:0] lu;
        uf = 1'b0;
        lu = '0;
        for (int k = 0; k < WB; k++) begin
            uf = 1'b0;
            lu = '0;
            for (int j = 0; j < WB; j++) begin
                if ((j <= k) && used_e[j]) begin
                    uf = 1'b1;
                    lu = WS'(j);
                end
            end
            run_at[k]  = uf ? (CW'(k) - CW'(lu)) : (r_carry + CW'(k + 1));
            hit_vec[k] = (run_at[k] >= CW'(r_count));
        end
        hk = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hk = WS'(k);
            end
        end
    end

    assign hit_raw  = |hit_vec;
    assign issue    = (r_rd_addr != r_scan_words);
    assign end_page = {r_ev_idx, hk};
    assign first_e  = EW'(end_page) + EW'(1) - EW'(r_count);

    assign start_e = EW'(r_start);
    assign fend_e  = start_e + EW'(r_count) - EW'(1);
    assign np_e    = EW'(NUM_PAGES);
    assign hi_e    = (fend_e >= np_e) ? (np_e - EW'(1)) : fend_e;

    assign lo_word   = r_lo[XW-1:WS];
    assign hi_word   = r_hi[XW-1:WS];
    assign lo_b      = (r_fw == lo_word) ? r_lo[WS-1:0] : '0;
    assign hi_b      = (r_fw == hi_word) ? r_hi[WS-1:0] : '1;

    always_comb begin
        for (int k = 0; k < WB; k++) begin
            fill_mask[k] = (WS'(k) >= lo_b) && (WS'(k) <= hi_b);
        end
    end

    assign fill_data = r_fill_val ? (ram_rdata | fill_mask) : (ram_rdata & ~fill_mask);

    assign ram_we    = i_cmd.clr_step | i_cmd.fill_wr;
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : r_fw;
    assign ram_wdata = i_cmd.clr_step ? '1 : fill_data;
    assign ram_raddr = i_cmd.fill_rd ? r_fw : r_rd_addr[AW-1:0];

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (NW),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr_addr == AW'(NW - 1));
        o_sts.cnt_zero   = (r_count == '0);
        o_sts.op_free    = r_op;
        o_sts.free_empty = (start_e >= np_e);
        o_sts.hit        = r_ev_vld && hit_raw;
        o_sts.nospace    = !issue && (!r_ev_vld || !hit_raw);
        o_sts.fill_last  = (r_fw == hi_word);
        o_sts.rsp_free   = !r_rsp_valid || i_rsp_ready;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_rsp_valid      = r_rsp_valid;
    assign o_rsp_status     = r_rsp_status;
    assign o_rsp_alloc_page = r_rsp_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_limit <= bpa_pkg::LIMIT_RESET;
            r_clr_addr   <= '0;
            r_ev_vld     <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_page_limit <= i_cfg_page_limit;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.disp_init) begin
                r_ev_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_ev_vld <= issue;
            end
            if (i_cmd.rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_op    <= i_req_op;
            r_count <= i_req_run_len;
            r_start <= i_req_start_page;
        end
        if (i_cmd.disp_init) begin
            r_res_page   <= '0;
            r_scan_words <= scan_words_n;
            r_lim        <= lim_cl;
            r_rd_addr    <= '0;
            r_carry      <= '0;
            r_lo         <= start_e[XW-1:0];
            r_hi         <= hi_e[XW-1:0];
            r_fill_val   <= 1'b0;
            r_fw         <= start_e[XW-1:WS];
        end
        if (i_cmd.scan_step) begin
            if (issue) begin
                r_rd_addr <= r_rd_addr + SW'(1);
                r_ev_idx  <= r_rd_addr[AW-1:0];
            end
            if (r_ev_vld) begin
                r_carry <= run_at[WB-1];
            end
        end
        if (i_cmd.hit_take) begin
            r_lo       <= first_e[XW-1:0];
            r_hi       <= end_page;
            r_fill_val <= 1'b1;
            r_fw       <= first_e[XW-1:WS];
            r_res_page <= first_e[bpa_pkg::PAGE_W-1:0];
        end
        if (i_cmd.fill_wr) begin
            r_fw <= r_fw + AW'(1);
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
        end
        if (i_cmd.rsp_load) begin
            r_rsp_status <= r_res_status;
            r_rsp_page   <= r_res_page;
        end
    end

    assign fill_ok = (r_fw >= lo_word) && (r_fw <= hi_word);
    assign hit_ok  = (EW'(end_page) < EW'(r_lim));
    assign rsp_ok  = !r_rsp_valid || i_rsp_ready;

    `BPA_ASSERT(a_fill_in_run, i_clk, i_rst_n, i_cmd.fill_wr |-> fill_ok, "fill outside run")
    `BPA_ASSERT(a_hit_below_limit, i_clk, i_rst_n, i_cmd.hit_take |-> hit_ok, "hit past limit")
    `BPA_ASSERT(a_rsp_no_overwrite, i_clk, i_rst_n, i_cmd.rsp_load |-> rsp_ok, "word overwritten")

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit page allocator over a used-bit map held in one RAM, 16 pages per word.
// After reset a clearing pass marks every page used, and no request is taken until
// it ends. A zero-count request is answered with a zero status. An allocate streams
// one bitmap word per cycle through the run finder, over ceil(min(page_limit,
// NUM_PAGES)/16) words, then marks the run by reading and writing back each bitmap
// word it touches; a free likewise reads and writes back each word touched. Results
// sit in an output register, so a new request is taken while one waits.

module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp,
    bpa_cfg_if.sink    i_cfg
);

    bpa_pkg::t_cmd cmd;
    bpa_pkg::t_sts sts;
    logic          req_ready;

    assign i_req.ready = req_ready;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bpa_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_op         (i_req.op),
        .i_req_run_len    (i_req.run_len),
        .i_req_start_page (i_req.start_page),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_page_limit (i_cfg.page_limit),
        .o_cfg_ready      (i_cfg.ready),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_status     (o_rsp.status),
        .o_rsp_alloc_page (o_rsp.alloc_page)
    );

endmodule

`default_nettype wire

// ===== test/tb_bitmap_page_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_top;

    localparam int   PAGES    = bpa_pkg::NUM_PAGES_DEF;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [bpa_pkg::COUNT_W-1:0] t_count;
    typedef logic [bpa_pkg::START_W-1:0] t_start;
    typedef logic [bpa_pkg::LIMIT_W-1:0] t_limit;
    typedef logic [bpa_pkg::PAGE_W-1:0]  t_page;

    typedef struct packed {
        logic   op;
        t_count run_len;
        t_start start_page;
    } t_req_word;

    typedef struct packed {
        bpa_pkg::t_status status;
        t_page            alloc_page;
    } t_rsp_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic   req_valid = 1'b0;
    logic   req_op    = OP_ALLOC;
    t_count req_count = '0;
    t_start req_start = '0;
    logic   rsp_ready = 1'b0;
    logic   cfg_valid = 1'b0;
    t_limit cfg_limit = '0;

    bpa_req_if req_bus ();
    bpa_rsp_if rsp_bus ();
    bpa_cfg_if cfg_bus ();

    assign req_bus.valid      = req_valid;
    assign req_bus.op         = req_op;
    assign req_bus.run_len    = req_count;
    assign req_bus.start_page = req_start;
    assign rsp_bus.ready      = rsp_ready;
    assign cfg_bus.valid      = cfg_valid;
    assign cfg_bus.page_limit = cfg_limit;

    bitmap_page_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [PAGES-1:0] page_used_map = '1;
    t_limit           limit_model   = bpa_pkg::LIMIT_RESET;

    t_req_word pending_q[$];
    t_rsp_word expected_rsp_q[$];

    bit          req_taken  = 1'b0;
    bit          cfg_taken  = 1'b0;
    bit          no_idle    = 1'b0;
    bit          hold_start = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned hold_cnt   = 0;
    int unsigned cfg_want   = 0;
    int unsigned cfg_writes = 0;
    t_limit      cfg_value  = '0;
    int unsigned failures   = 0;
    t_req_word   next_word;

    function automatic t_rsp_word apply_page_request(t_req_word w);
        t_rsp_word   r;
        int unsigned lim;
        int unsigned run;
        int unsigned first;
        int unsigned p;
        r.status     = bpa_pkg::ST_OK;
        r.alloc_page = '0;
        if (w.run_len == '0) begin
            r.status = bpa_pkg::ST_ZERO;
        end else if (w.op == OP_ALLOC) begin
            lim      = (int'(limit_model) > PAGES) ? PAGES : int'(limit_model);
            run      = 0;
            r.status = bpa_pkg::ST_NOSPACE;
            for (int i = 0; i < lim; i++) begin
                if (page_used_map[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == int'(w.run_len)) begin
                        first = i + 1 - int'(w.run_len);
                        for (int j = first; j <= i; j++) page_used_map[j] = 1'b1;
                        r.status     = bpa_pkg::ST_OK;
                        r.alloc_page = t_page'(first);
                        break;
                    end
                end
            end
        end else begin
            for (int i = 0; i < int'(w.run_len); i++) begin
                p = int'(w.start_page) + i;
                if (p < PAGES) page_used_map[p] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_req_word make_word(int unsigned span);
        t_req_word   w;
        int unsigned pick;
        w.op         = ($urandom_range(99) < 45) ? OP_FREE : OP_ALLOC;
        w.start_page = t_start'($urandom_range(PAGES - 1));
        pick         = $urandom_range(99);
        if (pick < 3) begin
            w.run_len = '0;
        end else if (pick < 5) begin
            w.run_len = t_count'($urandom_range(PAGES, 1));
        end else if (pick < 20) begin
            w.run_len = t_count'($urandom_range(64, 1));
        end else begin
            w.run_len = t_count'($urandom_range(12, 1));
        end
        if (w.op == OP_FREE && $urandom_range(99) < 80) begin
            w.start_page = t_start'($urandom_range(span - 1));
        end
        return w;
    endfunction

    task automatic queue_word(logic op, int unsigned count, int unsigned start);
        t_req_word w;
        w.op         = op;
        w.run_len    = t_count'(count);
        w.start_page = t_start'(start);
        pending_q.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(t_limit value);
        cfg_value = value;
        cfg_want++;
        while (cfg_writes != cfg_want) @(posedge i_clk);
    endtask

    // drive request and config words
    always @(negedge i_clk) begin
        if (cfg_valid && cfg_taken) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && cfg_want != cfg_writes) begin
            cfg_valid <= 1'b1;
            cfg_limit <= cfg_value;
        end
        if (!req_valid || req_taken) begin
            if (i_rst_n && pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 26)) begin
                next_word = pending_q.pop_front();
                req_valid <= 1'b1;
                req_op    <= next_word.op;
                req_count <= next_word.run_len;
                req_start <= next_word.start_page;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // hold off the result side once for a long stretch
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
        end else if (hold_start && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = 1500;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        t_rsp_word want;
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            if (cfg_valid && cfg_bus.ready) begin
                limit_model = cfg_limit;
                cfg_taken   = 1'b1;
                cfg_writes++;
            end
            if (rsp_bus.valid && rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result, status %0d page %0d", $time,
                             rsp_bus.status, rsp_bus.alloc_page);
                    failures++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.status, rsp_bus.status);
                        failures++;
                    end
                    if (rsp_bus.alloc_page !== want.alloc_page) begin
                        $display("%0t: alloc_page mismatch, expected %0d, actual %0d", $time,
                                 want.alloc_page, rsp_bus.alloc_page);
                        failures++;
                    end
                end
            end
            if (req_valid && req_bus.ready) begin
                expected_rsp_q.push_back(apply_page_request({req_op, req_count, req_start}));
                req_taken = 1'b1;
            end
        end
    end

    initial begin
        t_limit      limits[9];
        int unsigned span;
        limits = '{13'd64, 13'd300, 13'd4096, 13'd0, 13'd1, 13'd6000, 13'd17, 13'd1024, 13'd0};
        limits[8] = t_limit'($urandom_range(PAGES));
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_ALLOC, 0, 4095);
        queue_word(OP_FREE, 0, 5);
        queue_word(OP_FREE, PAGES, 0);
        queue_word(OP_ALLOC, PAGES, 0);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_FREE, PAGES, 4095);
        queue_word(OP_ALLOC, 1, 2730);
        queue_word(OP_FREE, 200, 4000);
        queue_word(OP_FREE, 50, 4000);
        queue_word(OP_ALLOC, 96, 0);
        queue_word(OP_ALLOC, PAGES, 0);
        queue_word(OP_FREE, 100, 0);
        queue_word(OP_ALLOC, 30, 0);
        queue_word(OP_ALLOC, 70, 0);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_FREE, 5, 10);
        queue_word(OP_FREE, 10, 20);
        queue_word(OP_ALLOC, 8, 0);
        queue_word(OP_ALLOC, 5, 0);
        queue_word(OP_FREE, PAGES - 1, 1);
        queue_word(OP_ALLOC, PAGES - 1, 1365);
        wait_idle();

        foreach (limits[k]) begin
            write_limit(limits[k]);
            span = (limits[k] < 16) ? 16 : ((limits[k] > PAGES) ? PAGES : limits[k]);
            no_idle    = (k == 2);
            hold_start = hold_start || (k == 0);
            for (int n = 0; n < 100; n++) pending_q.push_back(make_word(span));
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
